// ----- rtl/core/babr_pkg.sv -----
`timescale 1ns / 1ps

package babr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned MAX_BLOCK_DEF   = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned RING_RESET      = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned RING_W   = 11;

  localparam logic [OP_W-1:0] OP_WR_REQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_DATA = 2'd1;
  localparam logic [OP_W-1:0] OP_RD_REQ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 2'd2;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_WBYTE,
    KIND_RBLOCK
  } kind_e;

  // one classified item handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    len;
    logic [COUNT_W-1:0]  used;
    logic [COUNT_W-1:0]  free;
  } entry_t;

endpackage

// ----- rtl/core/babr_in_if.sv -----
`timescale 1ns / 1ps

interface babr_in_if
  import babr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [LEN_W-1:0]  block_length;
  logic [BYTE_W-1:0] data_in;

  modport source (output valid, output opcode, output block_length, output data_in,
                  input ready);
  modport sink (input valid, input opcode, input block_length, input data_in,
                output ready);
endinterface

// ----- rtl/core/babr_out_if.sv -----
`timescale 1ns / 1ps

interface babr_out_if
  import babr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   data_out;
  logic                last;
  logic [COUNT_W-1:0]  used_count;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output data_out, output last,
                  output used_count, output free_count, input ready);
  modport sink (input valid, input status, input data_out, input last,
                input used_count, input free_count, output ready);
endinterface

// ----- rtl/core/babr_ram.sv -----
`timescale 1ns / 1ps

module babr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/babr_queue.sv -----
`timescale 1ns / 1ps

module babr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/babr_front.sv -----
`timescale 1ns / 1ps

module babr_front
  import babr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned CW = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RING_W-1:0] cfg_wdata_i,
  babr_in_if.sink           req_i,
  output logic              push_o,
  output entry_t            entry_o,
  input  logic              full_i,
  output logic [CW-1:0]     ring_size_o
);

  localparam int unsigned WW = (CW > RING_W) ? CW : RING_W;
  localparam int unsigned RING_INIT = (RING_RESET > STORE_DEPTH) ? STORE_DEPTH : RING_RESET;

  logic [CW-1:0]    ring_q, ring_d;
  logic [CW-1:0]    used_q, used_d, free_q, free_d;
  logic [LEN_W-1:0] left_q, left_d, total_q, total_d;
  logic [WW-1:0]    cfg_wide;
  logic [CW-1:0]    len_c;
  logic             len_big, accept;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;
  assign push_o      = accept;
  assign ring_size_o = ring_q;
  assign cfg_wide    = WW'(cfg_wdata_i);
  assign len_c       = CW'(req_i.block_length);
  assign len_big     = (req_i.block_length > LEN_W'(MAX_BLOCK));

  always_comb begin
    ring_d  = ring_q;
    used_d  = used_q;
    free_d  = free_q;
    left_d  = left_q;
    total_d = total_q;
    entry_o.kind   = KIND_SINGLE;
    entry_o.status = ST_OK;
    entry_o.data   = req_i.data_in;
    entry_o.len    = req_i.block_length;
    if (cfg_we_i) begin
      if (cfg_wide == '0) begin
        ring_d = CW'(1);
      end else if (cfg_wide > WW'(STORE_DEPTH)) begin
        ring_d = CW'(STORE_DEPTH);
      end else begin
        ring_d = CW'(cfg_wide);
      end
      used_d  = '0;
      free_d  = ring_d;
      left_d  = '0;
      total_d = '0;
    end else if (accept) begin
      unique case (req_i.opcode)
        OP_WR_REQ: begin
          if (left_q != '0) begin
            entry_o.status = ST_UNEXPECTED;
          end else if (len_big || len_c > free_q) begin
            entry_o.status = ST_SHORT;
          end else begin
            free_d  = free_q - len_c;
            left_d  = req_i.block_length;
            total_d = req_i.block_length;
          end
        end
        OP_WR_DATA: begin
          if (left_q == '0) begin
            entry_o.status = ST_UNEXPECTED;
          end else begin
            entry_o.kind = KIND_WBYTE;
            left_d = left_q - 1'b1;
            if (left_q == LEN_W'(1)) begin
              used_d  = used_q + CW'(total_q);
              total_d = '0;
            end
          end
        end
        OP_RD_REQ: begin
          if (len_big || len_c > used_q) begin
            entry_o.status = ST_SHORT;
          end else if (req_i.block_length != '0) begin
            entry_o.kind = KIND_RBLOCK;
            used_d = used_q - len_c;
            free_d = free_q + len_c;
          end
        end
        default: begin
          entry_o.status = ST_UNEXPECTED;
        end
      endcase
    end
    entry_o.used = COUNT_W'(used_d);
    entry_o.free = COUNT_W'(free_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= CW'(RING_INIT);
      used_q  <= '0;
      free_q  <= CW'(RING_INIT);
      left_q  <= '0;
      total_q <= '0;
    end else begin
      ring_q  <= ring_d;
      used_q  <= used_d;
      free_q  <= free_d;
      left_q  <= left_d;
      total_q <= total_d;
    end
  end

endmodule

// ----- rtl/core/babr_back.sv -----
`timescale 1ns / 1ps

module babr_back
  import babr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned CW = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CW-1:0]     ring_size_i,
  input  logic              q_valid_i,
  input  entry_t            q_entry_i,
  output logic              q_pop_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [BYTE_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [BYTE_W-1:0] ram_rdata_i,
  babr_out_if.source        rsp_o
);

  logic [AW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LEN_W-1:0]    left_q, left_d;
  logic                pend_q, pend_d, pend_last_q, pend_last_d;
  logic [COUNT_W-1:0]  blk_used_q, blk_free_q;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [BYTE_W-1:0]   out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic [COUNT_W-1:0]  out_used_q, out_used_d, out_free_q, out_free_d;
  logic                busy, out_free, load_rd, issue, pop_single, pop_block;

  function automatic logic [AW-1:0] step_ptr(logic [AW-1:0] p, logic [CW-1:0] size);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= size) ? '0 : AW'(n);
  endfunction

  assign busy       = (left_q != '0);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign load_rd    = pend_q && out_free;
  assign issue      = busy && (!pend_q || load_rd);
  assign pop_single = q_valid_i && !busy && !pend_q && out_free
                      && (q_entry_i.kind != KIND_RBLOCK);
  assign pop_block  = q_valid_i && !busy && !pend_q && (q_entry_i.kind == KIND_RBLOCK);
  assign q_pop_o    = pop_single || pop_block;

  assign ram_we_o    = pop_single && (q_entry_i.kind == KIND_WBYTE);
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = q_entry_i.data;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_ptr_q;

  always_comb begin
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    left_d       = left_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    out_used_d   = out_used_q;
    out_free_d   = out_free_q;
    if (load_rd) begin
      pend_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_status_d = ST_OK;
      out_data_d   = ram_rdata_i;
      out_last_d   = pend_last_q;
      out_used_d   = blk_used_q;
      out_free_d   = blk_free_q;
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = (left_q == LEN_W'(1));
      left_d      = left_q - 1'b1;
      rd_ptr_d    = step_ptr(rd_ptr_q, ring_size_i);
    end
    if (pop_single) begin
      out_valid_d  = 1'b1;
      out_status_d = q_entry_i.status;
      out_data_d   = '0;
      out_last_d   = 1'b1;
      out_used_d   = q_entry_i.used;
      out_free_d   = q_entry_i.free;
      if (q_entry_i.kind == KIND_WBYTE) begin
        wr_ptr_d = step_ptr(wr_ptr_q, ring_size_i);
      end
    end
    if (pop_block) begin
      left_d = q_entry_i.len;
    end
    if (cfg_we_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q  <= pend_last_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    out_used_q   <= out_used_d;
    out_free_q   <= out_free_d;
    if (pop_block) begin
      blk_used_q <= q_entry_i.used;
      blk_free_q <= q_entry_i.free;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.last       = out_last_q;
  assign rsp_o.used_count = out_used_q;
  assign rsp_o.free_count = out_free_q;

endmodule

// ----- rtl/core/block_atomic_byte_ring.sv -----
`timescale 1ns / 1ps

// Circular byte buffer with whole-block writes and reads.
// req_i (valid/ready) carries opcode, block_length and data_in: a write
// request reserves space, write data bytes fill it and the last one commits
// the block, a read request streams that many committed bytes.
// rsp_o (valid/ready) returns status, data_out, last and the used/free
// counts as they stand after the whole request.
// A single-result item passes the queue and the output register; a read
// block passes the queue, then each byte the store's read register and
// the output register. Throughput: one single-result item per cycle while
// rsp_o is ready; a read block holds the back end, bounded by one read port.
// A two-entry queue splits the classifying front end from the back end, so
// requests keep being taken while a result waits; a stalled rsp_o fills the
// queue and then drops req_i.ready.
// Reset empties the ring with a ring size of 1024 (clamped to the store);
// writing cfg_wdata_i with cfg_we_i high sets the ring size and empties the
// ring. The store itself is not cleared.
module block_atomic_byte_ring
  import babr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RING_W-1:0] cfg_wdata_i,
  babr_in_if.sink           req_i,
  babr_out_if.source        rsp_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W;

  entry_t              push_entry, pop_entry;
  logic                push, full, q_valid, q_pop;
  logic [CW-1:0]       ring_size;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

  babr_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full),
    .ring_size_o (ring_size)
  );

  babr_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (pop_entry)
  );

  babr_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .ring_size_i (ring_size),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_o       (rsp_o)
  );

  babr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- bench/block_atomic_byte_ring_tb.sv -----
`timescale 1ns / 1ps

module block_atomic_byte_ring_tb;
  import babr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned     CYCLE_LIMIT = 1000000;
  localparam int unsigned     DRAIN_WAIT  = 20;
  localparam int unsigned     PRINT_CAP   = 40;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [COUNT_W-1:0]  used;
    logic [COUNT_W-1:0]  free;
  } ring_result_t;

  class byte_ring_scoreboard;
    logic [BYTE_W-1:0] store [STORE_DEPTH_DEF];
    int unsigned ring_bytes;
    int unsigned rd_idx;
    int unsigned wr_idx;
    int unsigned used_b;
    int unsigned free_b;
    int unsigned left_b;
    int unsigned total_b;
    ring_result_t awaited_rsp[$];

    function new();
      ring_bytes = RING_RESET;
      clear_ring();
    endfunction

    function void clear_ring();
      rd_idx  = 0;
      wr_idx  = 0;
      used_b  = 0;
      free_b  = ring_bytes;
      left_b  = 0;
      total_b = 0;
    endfunction

    function void set_size(logic [RING_W-1:0] v);
      if (v == 0) begin
        ring_bytes = 1;
      end else if (v > STORE_DEPTH_DEF) begin
        ring_bytes = STORE_DEPTH_DEF;
      end else begin
        ring_bytes = v;
      end
      clear_ring();
    endfunction

    function int unsigned wrap_next(int unsigned idx);
      return (idx + 1 >= ring_bytes) ? 0 : idx + 1;
    endfunction

    function void post(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] dat, logic lst);
      ring_result_t r;
      r.status = st;
      r.data   = dat;
      r.last   = lst;
      r.used   = used_b[COUNT_W-1:0];
      r.free   = free_b[COUNT_W-1:0];
      awaited_rsp.push_back(r);
    endfunction

    // note one accepted request and queue the responses it causes
    function void apply_request(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] dat);
      int unsigned n;
      logic [BYTE_W-1:0] grab[$];
      n = len;
      case (op)
        OP_WR_REQ: begin
          if (left_b != 0) begin
            post(ST_UNEXPECTED, '0, 1'b1);
          end else if (n > MAX_BLOCK_DEF || n > free_b) begin
            post(ST_SHORT, '0, 1'b1);
          end else begin
            free_b -= n;
            left_b  = n;
            total_b = n;
            post(ST_OK, '0, 1'b1);
          end
        end
        OP_WR_DATA: begin
          if (left_b == 0) begin
            post(ST_UNEXPECTED, '0, 1'b1);
          end else begin
            store[wr_idx] = dat;
            wr_idx = wrap_next(wr_idx);
            left_b--;
            if (left_b == 0) begin
              used_b += total_b;
              total_b = 0;
            end
            post(ST_OK, '0, 1'b1);
          end
        end
        OP_RD_REQ: begin
          if (n > MAX_BLOCK_DEF || n > used_b) begin
            post(ST_SHORT, '0, 1'b1);
          end else if (n == 0) begin
            post(ST_OK, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              grab.push_back(store[rd_idx]);
              rd_idx = wrap_next(rd_idx);
            end
            used_b -= n;
            free_b += n;
            foreach (grab[i]) post(ST_OK, grab[i], i == n - 1);
          end
        end
        default: post(ST_UNEXPECTED, '0, 1'b1);
      endcase
    endfunction

    // empty string when the response matches the oldest expectation
    function string check_response(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] dat,
                                   logic lst, logic [COUNT_W-1:0] used,
                                   logic [COUNT_W-1:0] free);
      ring_result_t want;
      string msg;
      msg = "";
      if (awaited_rsp.size() == 0) begin
        return $sformatf("response with none awaited: status=%0d data=%0h", st, dat);
      end
      want = awaited_rsp.pop_front();
      if (st !== want.status) msg = {msg, $sformatf(" status %0d/%0d", st, want.status)};
      if (dat !== want.data) msg = {msg, $sformatf(" data %0h/%0h", dat, want.data)};
      if (lst !== want.last) msg = {msg, $sformatf(" last %0b/%0b", lst, want.last)};
      if (used !== want.used) msg = {msg, $sformatf(" used %0d/%0d", used, want.used)};
      if (free !== want.free) msg = {msg, $sformatf(" free %0d/%0d", free, want.free)};
      return msg;
    endfunction

    function int unsigned awaited();
      return awaited_rsp.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [RING_W-1:0] cfg_wdata;

  babr_in_if  req_if ();
  babr_out_if rsp_if ();

  block_atomic_byte_ring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  byte_ring_scoreboard sb;
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned mismatches;
  int unsigned n_req;
  int unsigned n_rsp;
  int unsigned n_sizes;
  int unsigned cycle_count;

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t:%s", $time, msg);
  endtask

  // response side: check each transfer, then draw the next ready
  always @(posedge clk_i or negedge rst_ni) begin
    string msg;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_rsp++;
        msg = sb.check_response(rsp_if.status, rsp_if.data_out, rsp_if.last,
                                rsp_if.used_count, rsp_if.free_count);
        if (msg != "") report_mismatch(msg);
      end
      rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses awaited", cycle_count, sb.awaited());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                           logic [BYTE_W-1:0] dat);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.block_length <= len;
    req_if.data_in      <= dat;
    do @(posedge clk_i); while (!req_if.ready);
    sb.apply_request(op, len, dat);
    n_req++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited() != 0);
  endtask

  task automatic set_ring_size(logic [RING_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_size(v);
    n_sizes++;
  endtask

  // mostly fits, sometimes the whole room up to MAX_BLOCK_DEF, sometimes one past it
  function automatic int unsigned pick_len(int unsigned room);
    int unsigned cap;
    int unsigned r;
    cap = (room > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : room;
    r = $urandom_range(19);
    if (r == 0) return $urandom_range(127);
    if (r == 1) return room + 1;
    if (cap == 0) return 0;
    if (r < 4) return cap;
    if (r < 6) return 1;
    return $urandom_range(cap, 1);
  endfunction

  task automatic run_directed();
    send_item(OP_RD_REQ, 7'd0, 8'h00);
    send_item(OP_RD_REQ, 7'd1, 8'hFF);
    send_item(OP_WR_DATA, 7'd127, 8'hFF);
    send_item(OP_UNUSED, 7'd127, 8'hFF);
    send_item(OP_UNUSED, 7'd0, 8'h00);
    send_item(OP_WR_REQ, 7'd127, 8'h00);
    send_item(OP_WR_REQ, 7'd65, 8'h00);
    send_item(OP_WR_REQ, 7'd0, 8'h00);
    send_item(OP_WR_DATA, 7'd0, 8'h3C);
    send_item(OP_WR_REQ, 7'd3, 8'h00);
    send_item(OP_WR_DATA, 7'd0, 8'hFF);
    send_item(OP_WR_REQ, 7'd5, 8'h00);
    send_item(OP_RD_REQ, 7'd1, 8'h00);
    send_item(OP_RD_REQ, 7'd0, 8'h00);
    send_item(OP_WR_DATA, 7'd64, 8'h00);
    send_item(OP_WR_DATA, 7'd0, 8'hA5);
    send_item(OP_RD_REQ, 7'd4, 8'h00);
    send_item(OP_RD_REQ, 7'd3, 8'h5A);
    send_item(OP_RD_REQ, 7'd1, 8'h00);
    send_item(OP_RD_REQ, 7'd127, 8'h00);
  endtask

  // target counts every request sent, data bytes included
  task automatic run_random(int unsigned target, bit hold_mid);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    bit          held;
    start = n_req;
    held  = 1'b0;
    while (n_req - start < target) begin
      r = $urandom_range(99);
      if (r < 50) begin
        send_item(OP_WR_REQ, LEN_W'(pick_len(sb.free_b)), BYTE_W'($urandom_range(255)));
        n = sb.left_b;
        for (int i = 0; i < n && n_req - start < target; i++) begin
          if ($urandom_range(19) == 0) begin
            send_item(OP_RD_REQ, LEN_W'(pick_len(sb.used_b)), BYTE_W'($urandom_range(255)));
          end
          if ($urandom_range(29) == 0) begin
            send_item(OP_WR_REQ, LEN_W'($urandom_range(127)), BYTE_W'($urandom_range(255)));
          end
          send_item(OP_WR_DATA, LEN_W'($urandom_range(127)), BYTE_W'($urandom_range(255)));
        end
      end else if (r < 85) begin
        send_item(OP_RD_REQ, LEN_W'(pick_len(sb.used_b)), BYTE_W'($urandom_range(255)));
      end else begin
        case ($urandom_range(2))
          0: send_item(OP_UNUSED, LEN_W'($urandom_range(127)), BYTE_W'($urandom_range(255)));
          1: send_item(OP_WR_DATA, LEN_W'($urandom_range(127)), BYTE_W'($urandom_range(255)));
          default: send_item($urandom_range(1) ? OP_WR_REQ : OP_RD_REQ,
                             LEN_W'($urandom_range(127, 65)), BYTE_W'($urandom_range(255)));
        endcase
      end
      if (hold_mid && !held && n_req - start >= target / 2) begin
        held = 1'b1;
        wait_drained();
      end else if ($urandom_range(39) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    sb                  = new();
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_WR_REQ;
    req_if.block_length = '0;
    req_if.data_in      = '0;
    src_idle            = 23;
    snk_idle            = 80;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random(20, 1'b1);
    set_ring_size(11'd1);
    run_random(20, 1'b0);

    src_idle = 80;
    snk_idle = 23;
    set_ring_size(11'd2047);
    run_random(20, 1'b1);
    set_ring_size(11'd0);
    run_random(15, 1'b0);

    src_idle = 0;
    snk_idle = 0;
    set_ring_size(11'd37);
    run_random(20, 1'b0);
    set_ring_size(11'd1024);
    run_random(15, 1'b0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run: %0d requests, %0d responses, %0d ring size writes (1, 37, 1024, clamped 0",
             n_req, n_rsp, n_sizes);
    $display("  and 2047), refusals, stray data and wrapped block reads under mixed stalls");
    if (mismatches == 0 && sb.awaited() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/babr_pkg.sv
rtl/core/babr_in_if.sv
rtl/core/babr_out_if.sv
rtl/core/babr_ram.sv
rtl/core/babr_queue.sv
rtl/core/babr_front.sv
rtl/core/babr_back.sv
rtl/core/block_atomic_byte_ring.sv
bench/block_atomic_byte_ring_tb.sv
